// ===== design/amff_pkg.sv =====
// Shared types and constants for the manufacturer frame filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package amff_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_COMPANY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUFACTURER_TYPE = 2'd1;

    localparam logic [15:0] EXPECTED_COMPANY_RST  = 16'hFFFF;
    localparam logic [7:0]  MANUFACTURER_TYPE_RST = 8'hFF;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       accepted;
        logic       final_result;
    } t_out_item;

    // AD structure walk: length byte, type byte, value bytes
    typedef enum logic [1:0] {
        PH_LENGTH = 2'd0,
        PH_TYPE   = 2'd1,
        PH_VALUE  = 2'd2
    } t_phase;

    // Report request handed from the parser to the emitter
    typedef struct packed {
        logic valid;
        logic accepted;
    } t_job;

endpackage

`default_nettype wire

// ===== design/adv_manufacturer_frame_filter.sv =====
// Top level of the advertising manufacturer frame filter: input register,
// parser, two-bank frame memory, report queue and output register.
// Depends on amff_pkg and amff_parse.
//
// Takes one advertising payload byte per cycle unless the input stalls. When
// the last byte of a payload has been parsed the block reports FRAME_BYTES
// frame bytes (accepted set, final_result on the last) or a single reject
// result, one result per cycle while the output is not stalled. With nothing
// queued ahead, a report goes through the pending slot and active report to
// the output register. The frame memory has two banks so the next payload is
// parsed while the previous frame drains; one finished report can wait behind
// the one being emitted. The input stalls while an accepted frame waits in
// that slot, and a further payload's last byte stalls until the slot frees
// up. Configuration registers take effect on the next payload; the user must
// write them only while the block is idle, which the block does not enforce.
`default_nettype none

module adv_manufacturer_frame_filter import amff_pkg::*; #(
    parameter int FRAME_BYTES = 24,
    parameter int MAX_PAYLOAD = 31
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(FRAME_BYTES);
    localparam int AW = $clog2(2 * FRAME_BYTES);
    localparam logic [AW-1:0] BANK_OFS = AW'(FRAME_BYTES);
    localparam logic [IW-1:0] LAST_IDX = IW'(FRAME_BYTES - 1);

    // configuration
    logic [15:0] r_expected_company;
    logic [7:0]  r_manufacturer_type;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_company  <= EXPECTED_COMPANY_RST;
            r_manufacturer_type <= MANUFACTURER_TYPE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_EXPECTED_COMPANY:  r_expected_company  <= i_cfg_data;
                CFG_MANUFACTURER_TYPE: r_manufacturer_type <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // input register
    logic     r_in_valid;
    t_in_item r_in_item;
    logic     r_pend_valid;
    logic     r_pend_acc, r_pend_bank;
    logic     blocked;
    logic     step;

    // a waiting accepted frame holds one bank, so the parser's next bank may be in use
    assign blocked    = r_pend_valid && (r_in_item.last_byte || r_pend_acc);
    assign step       = r_in_valid && !blocked;
    assign o_in_stall = r_in_valid && blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) r_in_item <= i_in_data;
    end

    // parser
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic [7:0]    wr_data;
    t_job          job;

    amff_parse #(
        .FRAME_BYTES (FRAME_BYTES),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parse (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_step              (step),
        .i_item              (r_in_item),
        .i_expected_company  (r_expected_company),
        .i_manufacturer_type (r_manufacturer_type),
        .o_wr_en             (wr_en),
        .o_wr_idx            (wr_idx),
        .o_wr_data           (wr_data),
        .o_job               (job)
    );

    // report queue: one pending slot, one active report
    logic          r_wbank;
    logic          r_act_valid, r_act_acc, r_act_bank;
    logic [IW-1:0] r_idx;
    logic          r_out_valid, r_out_acc, r_out_final;
    logic [7:0]    r_mem_q;

    logic advance, emit, act_last, act_done, act_free, load_pend;

    assign advance   = !r_out_valid || !i_out_stall;
    assign emit      = r_act_valid && advance;
    assign act_last  = r_act_acc ? (r_idx == LAST_IDX) : 1'b1;
    assign act_done  = emit && act_last;
    assign act_free  = !r_act_valid || act_done;
    assign load_pend = r_pend_valid && act_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wbank      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_act_valid  <= 1'b0;
            r_idx        <= '0;
        end else begin
            // parser writes the other bank once an accepted frame is handed off
            if (job.valid && job.accepted) r_wbank <= !r_wbank;
            if (job.valid) begin
                r_pend_valid <= 1'b1;
            end else if (load_pend) begin
                r_pend_valid <= 1'b0;
            end
            if (load_pend) begin
                r_act_valid <= 1'b1;
                r_idx       <= '0;
            end else if (act_done) begin
                r_act_valid <= 1'b0;
            end else if (emit) begin
                r_idx <= r_idx + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (job.valid) begin
            r_pend_acc  <= job.accepted;
            r_pend_bank <= r_wbank;
        end
        if (load_pend) begin
            r_act_acc  <= r_pend_acc;
            r_act_bank <= r_pend_bank;
        end
    end

    // frame memory, two banks
    logic [7:0]    mem [2*FRAME_BYTES];
    logic [AW-1:0] wr_addr, rd_addr;

    assign wr_addr = (r_wbank ? BANK_OFS : '0) + AW'(wr_idx);
    assign rd_addr = (r_act_bank ? BANK_OFS : '0) + AW'(r_idx);

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (emit) r_mem_q <= mem[rd_addr];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_acc   <= r_act_acc;
            r_out_final <= act_last;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_out_data.frame_byte   = r_out_acc ? r_mem_q : 8'd0;
    assign o_out_data.accepted     = r_out_acc;
    assign o_out_data.final_result = r_out_final;

endmodule

`default_nettype wire

// ===== design/amff_parse.sv =====
// AD structure parser: walks one payload byte per step, captures the
// manufacturer value into the frame memory and issues one report per payload.
// Depends on amff_pkg.
`default_nettype none

module amff_parse import amff_pkg::*; #(
    parameter int FRAME_BYTES = 24,
    parameter int MAX_PAYLOAD = 31
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_step,
    input  wire t_in_item                       i_item,
    input  wire logic [15:0]                    i_expected_company,
    input  wire logic [7:0]                     i_manufacturer_type,
    output logic                                o_wr_en,
    output logic [$clog2(FRAME_BYTES)-1:0]      o_wr_idx,
    output logic [7:0]                          o_wr_data,
    output t_job                                o_job
);

    localparam int PW = $clog2(MAX_PAYLOAD + 1);
    localparam int FW = $clog2(FRAME_BYTES + 1);
    localparam int IW = $clog2(FRAME_BYTES);

    t_phase        r_phase, n_phase;
    logic [PW-1:0] r_pos, n_pos;
    logic [7:0]    r_rem, n_rem;
    logic          r_decided, n_decided;
    logic          r_verdict, n_verdict;
    logic          r_in_mfr, n_in_mfr;
    logic [FW-1:0] r_fill, n_fill;
    logic [7:0]    r_comp_lo, n_comp_lo;
    logic [7:0]    r_comp_hi, n_comp_hi;

    logic [7:0]    b;
    logic          proc;
    logic [7:0]    rem_dec;
    logic [7:0]    comp_hi_eff;
    logic          step_decided;
    logic          step_verdict;

    assign b       = i_item.payload_byte;
    // bytes past the payload limit or after the decision are dropped
    assign proc    = i_step && !r_decided && (r_pos < PW'(MAX_PAYLOAD));
    assign rem_dec = r_rem - 8'd1;

    assign o_wr_en   = proc && (r_phase == PH_VALUE) && r_in_mfr
                       && (r_fill < FW'(FRAME_BYTES));
    assign o_wr_idx  = r_fill[IW-1:0];
    assign o_wr_data = b;

    // high company byte may be the one arriving now when the frame is two bytes
    assign comp_hi_eff = (o_wr_en && (r_fill == FW'(1))) ? b : r_comp_hi;

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_rem     = r_rem;
        n_decided = r_decided;
        n_verdict = r_verdict;
        n_in_mfr  = r_in_mfr;
        n_fill    = r_fill;
        n_comp_lo = r_comp_lo;
        n_comp_hi = r_comp_hi;
        if (proc) begin
            n_pos = r_pos + PW'(1);
            unique case (r_phase)
                PH_TYPE: begin
                    n_rem = rem_dec;
                    if (b == i_manufacturer_type) begin
                        if (rem_dec != 8'(FRAME_BYTES)) begin
                            n_decided = 1'b1;
                            n_verdict = 1'b0;
                        end else begin
                            n_in_mfr = 1'b1;
                            n_fill   = '0;
                            n_phase  = PH_VALUE;
                        end
                    end else begin
                        n_phase = (rem_dec == 8'd0) ? PH_LENGTH : PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    n_rem = rem_dec;
                    if (r_in_mfr) begin
                        if (o_wr_en) begin
                            n_fill = r_fill + FW'(1);
                            if (r_fill == FW'(0)) n_comp_lo = b;
                            if (r_fill == FW'(1)) n_comp_hi = b;
                        end
                        if (rem_dec == 8'd0) begin
                            n_decided = 1'b1;
                            n_verdict = ({comp_hi_eff, r_comp_lo} == i_expected_company);
                        end
                    end else if (rem_dec == 8'd0) begin
                        n_phase = PH_LENGTH;
                    end
                end
                default: begin
                    if (b == 8'd0) begin
                        n_decided = 1'b1;
                        n_verdict = 1'b0;
                    end else begin
                        n_rem   = b;
                        n_phase = PH_TYPE;
                    end
                end
            endcase
        end
        // decision including this byte, taken before the end-of-payload clear
        step_decided = n_decided;
        step_verdict = n_verdict;
        if (i_step && i_item.last_byte) begin
            n_phase   = PH_LENGTH;
            n_pos     = '0;
            n_rem     = '0;
            n_decided = 1'b0;
            n_verdict = 1'b0;
            n_in_mfr  = 1'b0;
            n_fill    = '0;
            n_comp_lo = '0;
            n_comp_hi = '0;
        end
    end

    always_comb begin
        o_job.valid    = i_step && i_item.last_byte;
        o_job.accepted = step_decided && step_verdict;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LENGTH;
            r_pos     <= '0;
            r_rem     <= '0;
            r_decided <= 1'b0;
            r_verdict <= 1'b0;
            r_in_mfr  <= 1'b0;
            r_fill    <= '0;
            r_comp_lo <= '0;
            r_comp_hi <= '0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_rem     <= n_rem;
            r_decided <= n_decided;
            r_verdict <= n_verdict;
            r_in_mfr  <= n_in_mfr;
            r_fill    <= n_fill;
            r_comp_lo <= n_comp_lo;
            r_comp_hi <= n_comp_hi;
        end
    end

endmodule

`default_nettype wire

// ===== design/amff_checker.sv =====
// Port-level checks for the manufacturer frame filter, bound to the top level.
// Depends on amff_pkg and adv_manufacturer_frame_filter.
`default_nettype none

module amff_checker import amff_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result changed while stalled");

    a_reject_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.accepted
            |-> o_out_data.final_result && (o_out_data.frame_byte == 8'd0))
        else $error("reject result not final or not zero");

    a_frame_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out_data.accepted && !o_out_data.final_result
            |=> o_out_valid && o_out_data.accepted)
        else $error("gap inside an accepted frame");

endmodule

bind adv_manufacturer_frame_filter amff_checker u_amff_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
